### src/slrg_pkg.sv
// ----------------------------------------------------------------------------
// slrg_pkg
// Shared types, constants and the Lehmer step for the shuffled generator.
// ----------------------------------------------------------------------------
package slrg_pkg;

  localparam int VALUE_W = 31;
  localparam int MULT_W  = 15;
  localparam int PROD_W  = VALUE_W + MULT_W;

  localparam logic [MULT_W-1:0]  LEHMER_MULT = 15'd16807;
  localparam logic [VALUE_W-1:0] LEHMER_MOD  = 31'h7FFF_FFFF;
  localparam int WARMUP_EXTRA = 8;

  // configuration space
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int REG_SEED = 0;
  localparam logic [VALUE_W-1:0] SEED_RESET = 31'd1;

  typedef struct packed {
    logic load_seed;
    logic seed_step;
    logic draw;
    logic result_load;
  } slrg_cmd_t;

  typedef struct packed {
    logic seed_last;
  } slrg_status_t;

  // x * 16807 mod (2^31 - 1), folded as a Mersenne residue
  function automatic logic [VALUE_W-1:0] lehmer_step(input logic [VALUE_W-1:0] x);
    logic [PROD_W-1:0] prod;
    logic [VALUE_W:0]  fold;
    prod = PROD_W'(x) * PROD_W'(LEHMER_MULT);
    fold = (VALUE_W+1)'(prod[VALUE_W-1:0]) + (VALUE_W+1)'(prod[PROD_W-1:VALUE_W]);
    if (fold >= (VALUE_W+1)'(LEHMER_MOD)) begin
      fold = fold - (VALUE_W+1)'(LEHMER_MOD);
    end
    return fold[VALUE_W-1:0];
  endfunction

endpackage

### src/slrg_if.sv
// ----------------------------------------------------------------------------
// slrg_if
// Request and response channels of the shuffled generator.
// ----------------------------------------------------------------------------
interface slrg_req_if;
  logic valid;
  logic ready;
  logic reseed;

  modport source (output valid, output reseed, input ready);
  modport sink   (input valid, input reseed, output ready);
endinterface

interface slrg_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [slrg_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

### src/shuffled_lehmer_random_generator.sv
// ----------------------------------------------------------------------------
// shuffled_lehmer_random_generator
// Minimal-standard Lehmer generator behind a Bays-Durham shuffle table.
// ----------------------------------------------------------------------------
// Flow: a taken request goes through the draw state (registered table read)
//   and then the result state (result load), which waits while the output
//   stalls; the next request can be taken as the result loads. A reseed (or
//   the first request after reset) first seeds the table, stepping once per cycle.
// Reset: clears control state and sets seed to 1; the first request seeds.
// ----------------------------------------------------------------------------
module shuffled_lehmer_random_generator #(
  parameter int TABLE_SIZE = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  slrg_req_if.sink                     req,
  slrg_rsp_if.source                   rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [slrg_pkg::PADDR_W-1:0] paddr,
  input  logic [slrg_pkg::PDATA_W-1:0] pwdata,
  output logic [slrg_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import slrg_pkg::*;

  logic [VALUE_W-1:0] seed;
  logic               seed_sel;
  slrg_cmd_t          cmd;
  slrg_status_t       status;

  // Register space: one word per register, bit 2 of paddr picks the word.
  // Only the seed word exists; other words read as zero and drop writes.
  assign seed_sel = (paddr[PADDR_W-1:2] == (PADDR_W-2)'(REG_SEED));
  assign pready   = 1'b1;
  assign prdata   = seed_sel ? PDATA_W'(seed) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (psel && penable && pwrite && pready && seed_sel) begin
      seed <= pwdata[VALUE_W-1:0];
    end
  end

  // Controller: accepts an item, decides whether to seed first, then walks
  // draw and result states; the result register lets the next item in while
  // a finished value still waits downstream.
  slrg_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_reseed (req.reseed),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Datapath: generator register, shuffle table, slot select, result value.
  slrg_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk    (clk),
    .cmd    (cmd),
    .status (status),
    .seed   (seed),
    .value  (rsp.value)
  );

endmodule

### src/slrg_controller.sv
// ----------------------------------------------------------------------------
// slrg_controller
// Sequencer for seeding, drawing and handing off one item at a time.
// ----------------------------------------------------------------------------
module slrg_controller (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_reseed,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output slrg_pkg::slrg_cmd_t    cmd,
  input  slrg_pkg::slrg_status_t status
);
  import slrg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEED   = 4'b0010,
    ST_DRAW   = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   seeded;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SEED: begin
        cmd.seed_step = 1'b1;
        if (status.seed_last) begin
          state_next = ST_DRAW;
        end
      end
      ST_DRAW: begin
        cmd.draw   = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        // hold the finished value until the output register frees up
        if (out_free) begin
          cmd.result_load = 1'b1;
          in_ready        = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (in_valid && in_ready) begin
      if (in_reseed || !seeded) begin
        cmd.load_seed = 1'b1;
        state_next    = ST_SEED;
      end else begin
        state_next = ST_DRAW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seeded    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.seed_step && status.seed_last) begin
        seeded <= 1'b1;
      end
      if (cmd.result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### src/slrg_datapath.sv
// ----------------------------------------------------------------------------
// slrg_datapath
// Lehmer generator, shuffle table memory, slot selection and result register.
// ----------------------------------------------------------------------------
module slrg_datapath #(
  parameter int TABLE_SIZE = 32
) (
  input  logic                         clk,
  input  slrg_pkg::slrg_cmd_t          cmd,
  output slrg_pkg::slrg_status_t       status,
  input  logic [slrg_pkg::VALUE_W-1:0] seed,
  output logic [slrg_pkg::VALUE_W-1:0] value
);
  import slrg_pkg::*;

  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int SEED_STEPS = TABLE_SIZE + WARMUP_EXTRA;
  localparam int CNT_W      = $clog2(SEED_STEPS + 1);
  localparam longint SlotDiv = 1 + (longint'(LEHMER_MOD) - 1) / TABLE_SIZE;

  logic [VALUE_W-1:0] gen;
  logic [VALUE_W-1:0] gen_next;
  logic [VALUE_W-1:0] seed_fixed;
  logic [VALUE_W-1:0] last_output;
  logic [VALUE_W-1:0] rd_data;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_m1;
  logic [IDX_W-1:0]   slot;
  logic [IDX_W-1:0]   waddr;
  logic               we;
  logic [TABLE_SIZE:0] ge;
  logic [VALUE_W-1:0] mem [TABLE_SIZE];

  assign gen_next = lehmer_step(gen);
  // a seed that would lock the generator loads as one
  assign seed_fixed = (seed == '0 || seed == LEHMER_MOD) ? VALUE_W'(1) : seed;
  assign cnt_m1 = cnt - CNT_W'(1);
  assign status.seed_last = (cnt == CNT_W'(1));

  // slot = last_output / SlotDiv via constant thresholds (thermometer code)
  assign ge[0]          = 1'b1;
  assign ge[TABLE_SIZE] = 1'b0;
  for (genvar k = 1; k < TABLE_SIZE; k++) begin : g_thr
    localparam longint Thr = k * SlotDiv;
    assign ge[k] = ({1'b0, last_output} >= (VALUE_W+1)'(Thr));
  end

  always_comb begin
    slot = '0;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      if (ge[k] && !ge[k+1]) begin
        slot = slot | IDX_W'(k);
      end
    end
  end

  // seeding fills from the highest slot down; a draw refills the slot it read
  assign waddr = cmd.draw ? slot : cnt_m1[IDX_W-1:0];
  assign we    = cmd.draw || (cmd.seed_step && cnt_m1 < CNT_W'(TABLE_SIZE));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= gen_next;
    end
    if (cmd.draw) begin
      rd_data <= mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_seed) begin
      gen <= seed_fixed;
      cnt <= CNT_W'(SEED_STEPS);
    end else if (cmd.seed_step) begin
      gen <= gen_next;
      cnt <= cnt_m1;
    end else if (cmd.draw) begin
      gen <= gen_next;
    end
    if (cmd.seed_step && status.seed_last) begin
      last_output <= gen_next;
    end else if (cmd.result_load) begin
      last_output <= rd_data;
    end
    if (cmd.result_load) begin
      value <= rd_data;
    end
  end

endmodule

### src/slrg_checker.sv
// ----------------------------------------------------------------------------
// slrg_checker
// Port-level checks of the shuffled generator, bound to the top level.
// ----------------------------------------------------------------------------
module slrg_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [slrg_pkg::VALUE_W-1:0] rsp_value
);
  import slrg_pkg::*;

  // a stalled item stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_value))
    else $error("response value changed while stalled");

  // every value lies strictly inside the Lehmer range
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_value != '0) && (rsp_value != LEHMER_MOD))
    else $error("response value out of range");

  // a taken request keeps the block busy for at least the draw cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken back to back");

endmodule

bind shuffled_lehmer_random_generator slrg_checker u_slrg_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_value (rsp.value)
);
